FILE: rtl/body_to_world_accel_rotation_core_macros.svh
// assertion macros for the body-to-world rotation core
`ifndef BODY_TO_WORLD_ACCEL_ROTATION_CORE_MACROS_SVH
`define BODY_TO_WORLD_ACCEL_ROTATION_CORE_MACROS_SVH

// same-cycle implication
`define BWAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BWAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bwar_pkg.sv
package bwar_pkg;

  localparam int unsigned NumStages = 10;
  localparam int unsigned NumLanes  = 6;
  localparam int unsigned AccStages = 7;

  // trig lanes
  localparam int unsigned LaneSr = 0;
  localparam int unsigned LaneSp = 1;
  localparam int unsigned LaneSy = 2;
  localparam int unsigned LaneCr = 3;
  localparam int unsigned LaneCp = 4;
  localparam int unsigned LaneCy = 5;

  // angle to phase: 65536 phase steps per turn
  localparam logic [17:0] PhaseScale = 18'd166886;
  localparam logic [33:0] PhaseRound = 34'd32768;
  localparam logic [15:0] PhaseOfs   = 16'd17907;  // 83443 mod 2^16
  localparam logic [15:0] QuarterPh  = 16'd16384;

  // quintic quarter-wave sine
  localparam logic [14:0] QuarterOne = 15'd16384;
  localparam logic [10:0] PolyK1     = 11'd1160;
  localparam logic [13:0] PolyK2     = 14'd10512;
  localparam logic [14:0] PolyK3     = 15'd25736;

  localparam logic signed [63:0] RoundHalf = 64'sh0000_0200_0000_0000;
  localparam logic signed [23:0] Gravity   = 24'sd2511;
  localparam logic signed [23:0] OutLimit  = 24'sd40000;

  typedef logic        [15:0] phase_t;
  typedef logic signed [15:0] trig_t;
  typedef logic signed [15:0] acc_in_t;
  typedef logic signed [31:0] pair_t;
  typedef logic signed [45:0] mat_t;
  typedef logic signed [61:0] term_t;
  typedef logic signed [63:0] sum_t;
  typedef logic signed [16:0] acc_out_t;

  function automatic phase_t angle_to_phase(input logic [15:0] a);
    logic [15:0] u;
    logic [33:0] prod;
    logic [33:0] shifted;
    u       = {~a[15], a[14:0]};
    prod    = 34'(u) * 34'(PhaseScale);
    shifted = (prod + PhaseRound) >> 16;
    return shifted[15:0] - PhaseOfs;
  endfunction

  function automatic logic signed [23:0] round_q42(input sum_t v);
    sum_t        up;
    logic [63:0] mag;
    logic [63:0] dn;
    up  = (v + RoundHalf) >>> 42;
    mag = 64'(-v);
    dn  = (mag + 64'(RoundHalf)) >> 42;
    if (v >= 0) begin
      return up[23:0];
    end else begin
      return -$signed(dn[23:0]);
    end
  endfunction

  function automatic acc_out_t sat_out(input logic signed [23:0] v);
    if (v > OutLimit) begin
      return OutLimit[16:0];
    end else if (v < -OutLimit) begin
      return 17'(-OutLimit);
    end else begin
      return v[16:0];
    end
  endfunction

endpackage

FILE: rtl/body_to_world_accel_rotation_core.sv
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------------------
// in_     | request   | in_valid / in_ready   | roll, pitch, yaw (Q3.12), body accel x/y/z
// out_    | result    | out_valid / out_ready | world accel x, y, z minus gravity
//
// ten register stages: phase, four sine polynomial steps, pair products,
// matrix entries, accel products, axis sums, round and clamp
// one request enters per cycle, throughput one per cycle, while the output is not stalled
// synchronous active-low reset clears the valid bits only
// when the output holds an untaken result every stage holds; nothing is dropped
module body_to_world_accel_rotation_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_roll_angle,
  input  logic signed [15:0]       in_pitch_angle,
  input  logic signed [15:0]       in_yaw_angle,
  input  logic signed [15:0]       in_body_accel_x,
  input  logic signed [15:0]       in_body_accel_y,
  input  logic signed [15:0]       in_body_accel_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [16:0]       out_world_accel_x,
  output logic signed [16:0]       out_world_accel_y,
  output logic signed [16:0]       out_world_accel_z_net
);

`include "body_to_world_accel_rotation_core_macros.svh"

  // one valid bit per stage, last one is the output register
  logic [bwar_pkg::NumStages-1:0] vld_r;
  logic                           stage_en;

  assign stage_en  = !vld_r[bwar_pkg::NumStages-1] || out_ready;
  assign in_ready  = stage_en;
  assign out_valid = vld_r[bwar_pkg::NumStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (stage_en) begin
      vld_r <= {vld_r[bwar_pkg::NumStages-2:0], in_valid};
    end
  end

  // accel samples ride along until the product stage
  bwar_pkg::acc_in_t acc_pipe_r [bwar_pkg::AccStages][3];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      acc_pipe_r[0][0] <= in_body_accel_x;
      acc_pipe_r[0][1] <= in_body_accel_y;
      acc_pipe_r[0][2] <= in_body_accel_z;
      for (int s = 1; s < bwar_pkg::AccStages; s++) begin
        acc_pipe_r[s] <= acc_pipe_r[s-1];
      end
    end
  end

  // stage 0: angles wrapped to 16-bit phase
  bwar_pkg::phase_t ph_r [3];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      ph_r[0] <= bwar_pkg::angle_to_phase(in_roll_angle);
      ph_r[1] <= bwar_pkg::angle_to_phase(in_pitch_angle);
      ph_r[2] <= bwar_pkg::angle_to_phase(in_yaw_angle);
    end
  end

  // stages 1 to 4: six sine lanes (sines, then cosines as quarter-shifted sines)
  logic [14:0] z1_r  [bwar_pkg::NumLanes];
  logic [14:0] z2a_r [bwar_pkg::NumLanes];
  logic        ng1_r [bwar_pkg::NumLanes];
  logic [14:0] z2_r  [bwar_pkg::NumLanes];
  logic [14:0] z2b_r [bwar_pkg::NumLanes];
  logic [13:0] t1_r  [bwar_pkg::NumLanes];
  logic        ng2_r [bwar_pkg::NumLanes];
  logic [14:0] z3_r  [bwar_pkg::NumLanes];
  logic [14:0] t2_r  [bwar_pkg::NumLanes];
  logic        ng3_r [bwar_pkg::NumLanes];
  bwar_pkg::trig_t trig_r [bwar_pkg::NumLanes];

  bwar_pkg::phase_t lane_ph_nxt  [bwar_pkg::NumLanes];
  logic [14:0]      z_nxt        [bwar_pkg::NumLanes];
  logic [14:0]      z2_nxt       [bwar_pkg::NumLanes];
  logic [13:0]      t1_nxt       [bwar_pkg::NumLanes];
  logic [14:0]      t2_nxt       [bwar_pkg::NumLanes];
  bwar_pkg::trig_t  trig_nxt     [bwar_pkg::NumLanes];

  always_comb begin
    logic [29:0] sq;
    logic [25:0] k1p;
    logic [28:0] k2p;
    logic [29:0] k3p;
    for (int l = 0; l < 3; l++) begin
      lane_ph_nxt[l]   = ph_r[l];
      lane_ph_nxt[l+3] = ph_r[l] + bwar_pkg::QuarterPh;
    end
    for (int l = 0; l < bwar_pkg::NumLanes; l++) begin
      // fold odd quadrants onto the rising quarter wave
      z_nxt[l] = lane_ph_nxt[l][14] ? (bwar_pkg::QuarterOne - 15'(lane_ph_nxt[l][13:0]))
                                    : 15'(lane_ph_nxt[l][13:0]);
      sq          = 30'(z_nxt[l]) * 30'(z_nxt[l]);
      z2_nxt[l]   = sq[28:14];
      k1p         = 26'(z2a_r[l]) * 26'(bwar_pkg::PolyK1);
      t1_nxt[l]   = bwar_pkg::PolyK2 - k1p[27-2:14];
      k2p         = 29'(z2b_r[l]) * 29'(t1_r[l]);
      t2_nxt[l]   = bwar_pkg::PolyK3 - k2p[28:14];
      k3p         = 30'(z3_r[l]) * 30'(t2_r[l]);
      trig_nxt[l] = ng3_r[l] ? -$signed({1'b0, k3p[28:14]}) : $signed({1'b0, k3p[28:14]});
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      for (int l = 0; l < bwar_pkg::NumLanes; l++) begin
        z1_r[l]   <= z_nxt[l];
        z2a_r[l]  <= z2_nxt[l];
        ng1_r[l]  <= lane_ph_nxt[l][15];
        z2_r[l]   <= z1_r[l];
        z2b_r[l]  <= z2a_r[l];
        t1_r[l]   <= t1_nxt[l];
        ng2_r[l]  <= ng1_r[l];
        z3_r[l]   <= z2_r[l];
        t2_r[l]   <= t2_nxt[l];
        ng3_r[l]  <= ng2_r[l];
        trig_r[l] <= trig_nxt[l];
      end
    end
  end

  // stage 5: two-factor products, Q28
  bwar_pkg::pair_t cysp_r, sysp_r, cycp_r, sycr_r, sysr_r;
  bwar_pkg::pair_t sycp_r, cycr_r, cysr_r, cpsr_r, cpcr_r;
  bwar_pkg::trig_t sp_c_r, sr_c_r, cr_c_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      cysp_r <= trig_r[bwar_pkg::LaneCy] * trig_r[bwar_pkg::LaneSp];
      sysp_r <= trig_r[bwar_pkg::LaneSy] * trig_r[bwar_pkg::LaneSp];
      cycp_r <= trig_r[bwar_pkg::LaneCy] * trig_r[bwar_pkg::LaneCp];
      sycr_r <= trig_r[bwar_pkg::LaneSy] * trig_r[bwar_pkg::LaneCr];
      sysr_r <= trig_r[bwar_pkg::LaneSy] * trig_r[bwar_pkg::LaneSr];
      sycp_r <= trig_r[bwar_pkg::LaneSy] * trig_r[bwar_pkg::LaneCp];
      cycr_r <= trig_r[bwar_pkg::LaneCy] * trig_r[bwar_pkg::LaneCr];
      cysr_r <= trig_r[bwar_pkg::LaneCy] * trig_r[bwar_pkg::LaneSr];
      cpsr_r <= trig_r[bwar_pkg::LaneCp] * trig_r[bwar_pkg::LaneSr];
      cpcr_r <= trig_r[bwar_pkg::LaneCp] * trig_r[bwar_pkg::LaneCr];
      sp_c_r <= trig_r[bwar_pkg::LaneSp];
      sr_c_r <= trig_r[bwar_pkg::LaneSr];
      cr_c_r <= trig_r[bwar_pkg::LaneCr];
    end
  end

  // stage 6: rotation matrix entries, Q42
  bwar_pkg::mat_t mat_r [3][3];
  logic signed [47:0] m01, m02, m11, m12;

  always_comb begin
    m01 = cysp_r * sr_c_r;
    m02 = cysp_r * cr_c_r;
    m11 = sysp_r * sr_c_r;
    m12 = sysp_r * cr_c_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      mat_r[0][0] <= 46'(cycp_r) <<< 14;
      mat_r[0][1] <= 46'(m01) - (46'(sycr_r) <<< 14);
      mat_r[0][2] <= 46'(m02) + (46'(sysr_r) <<< 14);
      mat_r[1][0] <= 46'(sycp_r) <<< 14;
      mat_r[1][1] <= 46'(m11) + (46'(cycr_r) <<< 14);
      mat_r[1][2] <= 46'(m12) - (46'(cysr_r) <<< 14);
      mat_r[2][0] <= -(46'(sp_c_r) <<< 28);
      mat_r[2][1] <= 46'(cpsr_r) <<< 14;
      mat_r[2][2] <= 46'(cpcr_r) <<< 14;
    end
  end

  // stage 7: accel times matrix
  bwar_pkg::term_t term_r [3][3];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          term_r[i][j] <= acc_pipe_r[bwar_pkg::AccStages-1][j] * mat_r[i][j];
        end
      end
    end
  end

  // stage 8: per-axis sums
  bwar_pkg::sum_t sum_r [3];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= 64'(term_r[i][0]) + 64'(term_r[i][1]) + 64'(term_r[i][2]);
      end
    end
  end

  // stage 9: round half away from zero, remove gravity, clamp
  bwar_pkg::acc_out_t wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      wx_r <= bwar_pkg::sat_out(bwar_pkg::round_q42(sum_r[0]));
      wy_r <= bwar_pkg::sat_out(bwar_pkg::round_q42(sum_r[1]));
      wz_r <= bwar_pkg::sat_out(bwar_pkg::round_q42(sum_r[2]) - bwar_pkg::Gravity);
    end
  end

  assign out_world_accel_x     = wx_r;
  assign out_world_accel_y     = wy_r;
  assign out_world_accel_z_net = wz_r;

  // sine lanes never exceed unity
  logic trig_in_range;

  always_comb begin
    trig_in_range = 1'b1;
    for (int l = 0; l < bwar_pkg::NumLanes; l++) begin
      if (trig_r[l] > 16'sd16384 || trig_r[l] < -16'sd16384) begin
        trig_in_range = 1'b0;
      end
    end
  end

  `BWAR_ASSERT_NXT(a_stall_holds, !stage_en, $stable(vld_r), "pipeline moved while stalled")
  `BWAR_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_r[0], "accepted request lost")
  `BWAR_ASSERT_IMP(a_trig_range, vld_r[4], trig_in_range, "sine lane out of range")
  `BWAR_ASSERT_IMP(a_out_range, out_valid, (wz_r <= 17'sd40000) && (wz_r >= -17'sd40000),
    "vertical result beyond clamp")

endmodule
